>>> design/coapmp_pkg.sv
// ---------------------------------------------------------------------------
// CoAP message parser package
// Shared types and constants for the byte-stream CoAP datagram parser.
// ---------------------------------------------------------------------------
package coapmp_pkg;

   localparam logic [7:0]  MARKER_BYTE   = 8'hFF;
   localparam logic [1:0]  VERSION_ONE   = 2'b01;
   localparam logic [3:0]  TKL_MAX       = 4'd8;
   localparam logic [3:0]  NIB_EXT8      = 4'd13;
   localparam logic [3:0]  NIB_EXT16     = 4'd14;
   localparam logic [3:0]  NIB_RESERVED  = 4'd15;
   localparam logic [15:0] EXT8_OFFSET   = 16'd13;
   localparam logic [15:0] EXT16_OFFSET  = 16'd269;

   typedef enum logic [3:0] {
      PH_H0      = 4'd0,
      PH_H1      = 4'd1,
      PH_H2      = 4'd2,
      PH_H3      = 4'd3,
      PH_TOKEN   = 4'd4,
      PH_OPTHDR  = 4'd5,
      PH_DEXT1   = 4'd6,
      PH_DEXT2H  = 4'd7,
      PH_DEXT2L  = 4'd8,
      PH_LEXT1   = 4'd9,
      PH_LEXT2H  = 4'd10,
      PH_LEXT2L  = 4'd11,
      PH_VALUE   = 4'd12,
      PH_PAYLOAD = 4'd13
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_TOKEN   = 3'd1,
      KIND_OPTION  = 3'd2,
      KIND_VALUE   = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_END     = 3'd5,
      KIND_ERROR   = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_HEADER_SHORT = 4'd1,
      ERR_VERSION      = 4'd2,
      ERR_TOKEN_LENGTH = 4'd3,
      ERR_TOKEN_SHORT  = 4'd4,
      ERR_DELTA_15     = 4'd5,
      ERR_LENGTH_15    = 4'd6,
      ERR_OPTHDR_SHORT = 4'd7,
      ERR_VALUE_SHORT  = 4'd8
   } error_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  byte_counter;
      logic [23:0] header_hold;
      logic [15:0] option_number_sum;
      logic [15:0] pending_delta;
      logic [15:0] pending_length;
      logic [7:0]  extension_high_byte;
      logic [15:0] remaining_count;
      logic        discarding;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:               PH_H0,
      byte_counter:        4'd0,
      header_hold:         24'd0,
      option_number_sum:   16'd0,
      pending_delta:       16'd0,
      pending_length:      16'd0,
      extension_high_byte: 8'd0,
      remaining_count:     16'd0,
      discarding:          1'b0
   };

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  code;
      logic [15:0] message_id;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic [7:0]  data_value;
      error_type   error_code;
      logic        field_last;
      logic        message_end;
   } result_type;

endpackage

>>> design/coap_message_parser_core.sv
// ---------------------------------------------------------------------------
// CoAP message parser core
// Streaming CoAP datagram parser: one byte per transaction in, at most one
// result transaction out per byte (header, token, option, value, payload,
// end or error).
// A result is registered and presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register is refilled
// in the cycle it is drained, so only a stalled result holds the input.
// Reset: synchronous, clears the parser state and the output valid.
// ---------------------------------------------------------------------------
module coap_message_parser_core
   import coapmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tlast,  // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] msg_type, [5:2] token_length, [13:6] code, [29:14] message_id,
   // [45:30] option_number, [61:46] option_length, [69:62] data_value,
   // [73:70] error_code, [79:74] zero
   output logic [79:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,  // [2:0] kind, [3] field_last
   output logic        rsp_tlast   // message_end
);

   parse_state_type state_ff;
   parse_state_type state_in;
   logic            result_hit;
   result_type      result;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   result_type      rsp_data_ff;
   logic            req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   coapmp_step u_step (
      .state_cur  (state_ff),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .state_nxt  (state_in),
      .result_hit (result_hit),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_accept) begin
         rsp_valid_in = result_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result_hit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0,
                        rsp_data_ff.error_code,
                        rsp_data_ff.data_value,
                        rsp_data_ff.option_length,
                        rsp_data_ff.option_number,
                        rsp_data_ff.message_id,
                        rsp_data_ff.code,
                        rsp_data_ff.token_length,
                        rsp_data_ff.msg_type};
   assign rsp_tuser  = {rsp_data_ff.field_last, rsp_data_ff.kind};
   assign rsp_tlast  = rsp_data_ff.message_end;

endmodule

>>> design/coapmp_step.sv
// ---------------------------------------------------------------------------
// CoAP message parser step
// Next parser state and result for one received byte.
// ---------------------------------------------------------------------------
module coapmp_step
   import coapmp_pkg::*;
(
   input  parse_state_type state_cur,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output parse_state_type state_nxt,
   output logic            result_hit,
   output result_type      result
);

   always_comb begin
      parse_state_type nx;
      result_type      res;
      logic            hit;
      logic            err;
      error_type       err_code;
      logic            emit;
      logic            go_after;
      logic            go_finish;
      logic [3:0]      dn;
      logic [3:0]      nib;
      logic [3:0]      tkl;
      logic [3:0]      cnt;
      logic [15:0]     sum;

      nx        = state_cur;
      res       = '0;
      hit       = 1'b0;
      err       = 1'b0;
      err_code  = ERR_NONE;
      emit      = 1'b0;
      go_after  = 1'b0;
      go_finish = 1'b0;
      dn        = data_byte[7:4];
      nib       = 4'd0;
      tkl       = state_cur.header_hold[19:16];
      cnt       = state_cur.byte_counter + 4'd1;
      sum       = 16'd0;

      if (state_cur.discarding) begin
         if (last_byte) begin
            nx = STATE_RESET;
         end
      end else begin
         unique case (state_cur.phase)
            PH_H1, PH_H2: begin
               nx.header_hold = {state_cur.header_hold[15:0], data_byte};
               if (last_byte) begin
                  err      = 1'b1;
                  err_code = ERR_HEADER_SHORT;
               end else if (state_cur.phase == PH_H1) begin
                  nx.phase = PH_H2;
               end else begin
                  nx.phase = PH_H3;
               end
            end
            PH_H3: begin
               if (state_cur.header_hold[23:22] != VERSION_ONE) begin
                  err      = 1'b1;
                  err_code = ERR_VERSION;
               end else if (tkl > TKL_MAX) begin
                  err      = 1'b1;
                  err_code = ERR_TOKEN_LENGTH;
               end else if (last_byte && tkl != 4'd0) begin
                  err      = 1'b1;
                  err_code = ERR_TOKEN_SHORT;
               end else begin
                  res.kind         = KIND_HEADER;
                  res.msg_type     = state_cur.header_hold[21:20];
                  res.token_length = tkl;
                  res.code         = state_cur.header_hold[15:8];
                  res.message_id   = {state_cur.header_hold[7:0], data_byte};
                  nx.byte_counter  = 4'd0;
                  nx.phase         = (tkl != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                  emit             = 1'b1;
               end
            end
            PH_TOKEN: begin
               nx.byte_counter = cnt;
               if (last_byte && cnt < tkl) begin
                  err      = 1'b1;
                  err_code = ERR_TOKEN_SHORT;
               end else begin
                  res.kind       = KIND_TOKEN;
                  res.data_value = data_byte;
                  if (cnt >= tkl) begin
                     res.field_last = 1'b1;
                     nx.phase       = PH_OPTHDR;
                  end
                  emit = 1'b1;
               end
            end
            PH_OPTHDR: begin
               if (data_byte == MARKER_BYTE) begin
                  if (last_byte) begin
                     res.kind = KIND_END;
                     emit     = 1'b1;
                  end else begin
                     nx.phase = PH_PAYLOAD;
                  end
               end else begin
                  nx.pending_length = {12'd0, data_byte[3:0]};
                  if (dn == NIB_RESERVED) begin
                     err      = 1'b1;
                     err_code = ERR_DELTA_15;
                  end else if (dn == NIB_EXT8 || dn == NIB_EXT16) begin
                     if (last_byte) begin
                        err      = 1'b1;
                        err_code = ERR_OPTHDR_SHORT;
                     end else begin
                        nx.phase = (dn == NIB_EXT8) ? PH_DEXT1 : PH_DEXT2H;
                     end
                  end else begin
                     nx.pending_delta = {12'd0, dn};
                     go_after         = 1'b1;
                  end
               end
            end
            PH_DEXT1: begin
               nx.pending_delta = {8'd0, data_byte} + EXT8_OFFSET;
               go_after         = 1'b1;
            end
            PH_DEXT2H, PH_LEXT2H: begin
               if (last_byte) begin
                  err      = 1'b1;
                  err_code = ERR_OPTHDR_SHORT;
               end else begin
                  nx.extension_high_byte = data_byte;
                  nx.phase = (state_cur.phase == PH_DEXT2H) ? PH_DEXT2L : PH_LEXT2L;
               end
            end
            PH_DEXT2L: begin
               nx.pending_delta = {state_cur.extension_high_byte, data_byte} + EXT16_OFFSET;
               go_after         = 1'b1;
            end
            PH_LEXT1: begin
               nx.pending_length = {8'd0, data_byte} + EXT8_OFFSET;
               go_finish         = 1'b1;
            end
            PH_LEXT2L: begin
               nx.pending_length = {state_cur.extension_high_byte, data_byte}
                                   + EXT16_OFFSET;
               go_finish         = 1'b1;
            end
            PH_VALUE: begin
               if (last_byte && state_cur.remaining_count > 16'd1) begin
                  err      = 1'b1;
                  err_code = ERR_VALUE_SHORT;
               end else begin
                  res.kind          = KIND_VALUE;
                  res.option_number = state_cur.option_number_sum;
                  res.option_length = state_cur.pending_length;
                  res.data_value    = data_byte;
                  if (state_cur.remaining_count <= 16'd1) begin
                     nx.remaining_count = 16'd0;
                     res.field_last     = 1'b1;
                     nx.phase           = PH_OPTHDR;
                  end else begin
                     nx.remaining_count = state_cur.remaining_count - 16'd1;
                  end
                  emit = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               res.kind       = KIND_PAYLOAD;
               res.data_value = data_byte;
               emit           = 1'b1;
            end
            default: begin
               // header first byte, also any unused phase code
               nx             = STATE_RESET;
               nx.header_hold = {16'd0, data_byte};
               if (last_byte) begin
                  err      = 1'b1;
                  err_code = ERR_HEADER_SHORT;
               end else begin
                  nx.phase = PH_H1;
               end
            end
         endcase

         if (go_after) begin
            nib = nx.pending_length[3:0];
            if (nib == NIB_RESERVED) begin
               err      = 1'b1;
               err_code = ERR_LENGTH_15;
            end else if (nib == NIB_EXT8 || nib == NIB_EXT16) begin
               if (last_byte) begin
                  err      = 1'b1;
                  err_code = ERR_OPTHDR_SHORT;
               end else begin
                  nx.phase = (nib == NIB_EXT8) ? PH_LEXT1 : PH_LEXT2H;
               end
            end else begin
               go_finish = 1'b1;
            end
         end

         if (go_finish) begin
            sum                  = state_cur.option_number_sum + nx.pending_delta;
            nx.option_number_sum = sum;
            if (nx.pending_length != 16'd0 && last_byte) begin
               err      = 1'b1;
               err_code = ERR_VALUE_SHORT;
            end else begin
               if (nx.pending_length != 16'd0) begin
                  nx.remaining_count = nx.pending_length;
                  nx.phase           = PH_VALUE;
               end else begin
                  nx.phase = PH_OPTHDR;
               end
               res.kind          = KIND_OPTION;
               res.option_number = sum;
               res.option_length = nx.pending_length;
               emit              = 1'b1;
            end
         end

         if (err) begin
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = err_code;
            hit            = 1'b1;
            if (last_byte) begin
               nx = STATE_RESET;
            end else begin
               nx.discarding = 1'b1;
            end
         end else if (emit) begin
            hit = 1'b1;
            if (last_byte) begin
               res.message_end = 1'b1;
               nx              = STATE_RESET;
            end
         end
      end

      state_nxt  = nx;
      result_hit = hit;
      result     = res;
   end

endmodule

>>> tb/coap_message_parser_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CoAP message parser core testbench
// Feeds whole datagrams (well-formed, truncated, corrupted and noise) one
// byte per transaction, with random idle and stall cycles on both sides,
// and compares every result transaction field by field with a predicted
// copy of the parser.
// ---------------------------------------------------------------------------
module coap_message_parser_core_tb
   import coapmp_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TARGET_BYTES = 1150;

   class coap_parse_scoreboard;
      phase_type   ph;
      logic [3:0]  tok_seen;
      logic [23:0] hdr;
      logic [15:0] opt_sum;
      logic [15:0] delta;
      logic [15:0] olen;
      logic [15:0] left;
      logic [7:0]  ext_hi;
      bit          dropping;
      result_type  expected_results[$];
      int          mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         ph       = PH_H0;
         tok_seen = '0;
         hdr      = '0;
         opt_sum  = '0;
         delta    = '0;
         olen     = '0;
         left     = '0;
         ext_hi   = '0;
         dropping = 1'b0;
      endfunction

      function bit raise_error(inout result_type r, input error_type e, input bit last);
         r.kind       = KIND_ERROR;
         r.error_code = e;
         if (last) restart();
         else dropping = 1'b1;
         return 1'b1;
      endfunction

      function bit finish(inout result_type r, input kind_type k, input bit last);
         r.kind = k;
         if (last) begin
            r.message_end = 1'b1;
            restart();
         end
         return 1'b1;
      endfunction

      function bit close_option(inout result_type r, input bit last);
         opt_sum = opt_sum + delta;
         if (olen != 16'd0) begin
            if (last) return raise_error(r, ERR_VALUE_SHORT, 1'b1);
            left = olen;
            ph   = PH_VALUE;
         end else begin
            ph = PH_OPTHDR;
         end
         r.option_number = opt_sum;
         r.option_length = olen;
         return finish(r, KIND_OPTION, last);
      endfunction

      // delta is settled; the length nibble still sits in olen
      function bit after_delta(inout result_type r, input bit last);
         if (olen == 16'(NIB_RESERVED)) return raise_error(r, ERR_LENGTH_15, last);
         if (olen == 16'(NIB_EXT8) || olen == 16'(NIB_EXT16)) begin
            if (last) return raise_error(r, ERR_OPTHDR_SHORT, 1'b1);
            ph = (olen == 16'(NIB_EXT8)) ? PH_LEXT1 : PH_LEXT2H;
            return 1'b0;
         end
         return close_option(r, last);
      endfunction

      function bit parse_byte(input logic [7:0] b, input bit last, output result_type r);
         logic [3:0] tkl;
         logic [3:0] dn;
         r = '0;
         if (dropping) begin
            if (last) restart();
            return 1'b0;
         end
         case (ph)
            PH_H1, PH_H2: begin
               hdr = {hdr[15:0], b};
               if (last) return raise_error(r, ERR_HEADER_SHORT, 1'b1);
               ph = (ph == PH_H1) ? PH_H2 : PH_H3;
               return 1'b0;
            end
            PH_H3: begin
               if (hdr[23:22] != VERSION_ONE) return raise_error(r, ERR_VERSION, last);
               tkl = hdr[19:16];
               if (tkl > TKL_MAX) return raise_error(r, ERR_TOKEN_LENGTH, last);
               if (last && tkl != 4'd0) return raise_error(r, ERR_TOKEN_SHORT, 1'b1);
               r.msg_type     = hdr[21:20];
               r.token_length = tkl;
               r.code         = hdr[15:8];
               r.message_id   = {hdr[7:0], b};
               tok_seen       = '0;
               ph             = (tkl != 4'd0) ? PH_TOKEN : PH_OPTHDR;
               return finish(r, KIND_HEADER, last);
            end
            PH_TOKEN: begin
               tkl      = hdr[19:16];
               tok_seen = tok_seen + 4'd1;
               if (last && tok_seen < tkl) return raise_error(r, ERR_TOKEN_SHORT, 1'b1);
               r.data_value = b;
               if (tok_seen >= tkl) begin
                  r.field_last = 1'b1;
                  ph           = PH_OPTHDR;
               end
               return finish(r, KIND_TOKEN, last);
            end
            PH_OPTHDR: begin
               if (b == MARKER_BYTE) begin
                  if (last) return finish(r, KIND_END, 1'b1);
                  ph = PH_PAYLOAD;
                  return 1'b0;
               end
               dn   = b[7:4];
               olen = {12'd0, b[3:0]};
               if (dn == NIB_RESERVED) return raise_error(r, ERR_DELTA_15, last);
               if (dn == NIB_EXT8 || dn == NIB_EXT16) begin
                  if (last) return raise_error(r, ERR_OPTHDR_SHORT, 1'b1);
                  ph = (dn == NIB_EXT8) ? PH_DEXT1 : PH_DEXT2H;
                  return 1'b0;
               end
               delta = {12'd0, dn};
               return after_delta(r, last);
            end
            PH_DEXT1: begin
               delta = {8'd0, b} + EXT8_OFFSET;
               return after_delta(r, last);
            end
            PH_DEXT2H, PH_LEXT2H: begin
               if (last) return raise_error(r, ERR_OPTHDR_SHORT, 1'b1);
               ext_hi = b;
               ph     = (ph == PH_DEXT2H) ? PH_DEXT2L : PH_LEXT2L;
               return 1'b0;
            end
            PH_DEXT2L: begin
               delta = {ext_hi, b} + EXT16_OFFSET;
               return after_delta(r, last);
            end
            PH_LEXT1: begin
               olen = {8'd0, b} + EXT8_OFFSET;
               return close_option(r, last);
            end
            PH_LEXT2L: begin
               olen = {ext_hi, b} + EXT16_OFFSET;
               return close_option(r, last);
            end
            PH_VALUE: begin
               if (last && left > 16'd1) return raise_error(r, ERR_VALUE_SHORT, 1'b1);
               r.option_number = opt_sum;
               r.option_length = olen;
               r.data_value    = b;
               if (left <= 16'd1) begin
                  left         = '0;
                  r.field_last = 1'b1;
                  ph           = PH_OPTHDR;
               end else begin
                  left = left - 16'd1;
               end
               return finish(r, KIND_VALUE, last);
            end
            PH_PAYLOAD: begin
               r.data_value = b;
               return finish(r, KIND_PAYLOAD, last);
            end
            default: begin
               restart();
               hdr = {16'd0, b};
               if (last) return raise_error(r, ERR_HEADER_SHORT, 1'b1);
               ph = PH_H1;
               return 1'b0;
            end
         endcase
      endfunction

      // returns 1 unless the byte fell into a dropped datagram tail
      function bit note_byte(logic [7:0] b, bit last);
         result_type r;
         bit         live;
         live = !dropping;
         if (parse_byte(b, last, r)) expected_results.push_back(r);
         return live;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none got kind %0h", $time, got.kind);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("kind",          16'(want.kind),          16'(got.kind));
         compare_field("msg_type",      16'(want.msg_type),      16'(got.msg_type));
         compare_field("token_length",  16'(want.token_length),  16'(got.token_length));
         compare_field("code",          16'(want.code),          16'(got.code));
         compare_field("message_id",    want.message_id,         got.message_id);
         compare_field("option_number", want.option_number,      got.option_number);
         compare_field("option_length", want.option_length,      got.option_length);
         compare_field("data_value",    16'(want.data_value),    16'(got.data_value));
         compare_field("error_code",    16'(want.error_code),    16'(got.error_code));
         compare_field("field_last",    16'(want.field_last),    16'(got.field_last));
         compare_field("message_end",   16'(want.message_end),   16'(got.message_end));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;  // [7:0] data_byte
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [1:0] msg_type, [5:2] token_length, [13:6] code, [29:14] message_id,
   // [45:30] option_number, [61:46] option_length, [69:62] data_value,
   // [73:70] error_code, [79:74] zero
   logic [79:0] rsp_tdata;
   logic [3:0]  rsp_tuser;        // [2:0] kind, [3] field_last
   logic        rsp_tlast;        // message_end

   coap_parse_scoreboard board;
   logic [7:0] datagram[$];
   int         live_bytes = 0;
   int         cycle_count = 0;
   int         req_calm = 0;
   int         rsp_calm = 0;

   coap_message_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("coap_message_parser_core_tb NOT OK");
         $finish;
      end
   end

   // idle cycles before the next transaction, with occasional calm stretches
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 8);
   endfunction

   task automatic send_datagram();
      int gap;
      bit last;
      foreach (datagram[i]) begin
         gap  = draw_wait(req_calm);
         last = (i == datagram.size() - 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= datagram[i];
         req_tlast  <= last;
         do @(posedge clock); while (!req_tready);
         if (board.note_byte(datagram[i], last)) live_bytes++;
      end
   endtask

   // wild: any nibble, full-range length extension, value of one to three bytes
   function automatic void add_option(bit wild);
      logic [3:0]  dn;
      logic [3:0]  ln;
      logic [15:0] dext;
      logic [15:0] lext;
      int          pick;
      int          vlen;
      pick = $urandom_range(0, 9);
      dn   = (pick < 6) ? 4'($urandom_range(0, 12)) : (pick < 8) ? NIB_EXT8 : NIB_EXT16;
      pick = $urandom_range(0, 39);
      if (pick < 27) ln = 4'($urandom_range(0, 12));
      else if (pick < 39 || $urandom_range(0, 3) != 0) ln = NIB_EXT8;
      else ln = NIB_EXT16;
      dext = 16'($urandom_range(0, 65535));
      lext = (ln == NIB_EXT8) ? 16'($urandom_range(0, 20)) : 16'($urandom_range(0, 3));
      if (wild) begin
         dn   = 4'($urandom_range(0, 15));
         ln   = 4'($urandom_range(0, 15));
         lext = 16'($urandom_range(0, 65535));
      end
      datagram.push_back({dn, ln});
      if (dn == NIB_EXT8) datagram.push_back(dext[7:0]);
      if (dn == NIB_EXT16) begin
         datagram.push_back(dext[15:8]);
         datagram.push_back(dext[7:0]);
      end
      if (ln == NIB_EXT8) datagram.push_back(lext[7:0]);
      if (ln == NIB_EXT16) begin
         datagram.push_back(lext[15:8]);
         datagram.push_back(lext[7:0]);
      end
      vlen = (ln == NIB_EXT8) ? lext[7:0] + 13 : (ln == NIB_EXT16) ? lext + 269 : ln;
      if (wild) vlen = $urandom_range(1, 3);
      repeat (vlen) datagram.push_back(8'($urandom));
   endfunction

   function automatic void build_message(bit with_payload);
      int tkl;
      int pick;
      datagram.delete();
      tkl = $urandom_range(0, 8);
      datagram.push_back({VERSION_ONE, 2'($urandom_range(0, 3)), 4'(tkl)});
      repeat (3) datagram.push_back(8'($urandom));
      repeat (tkl) datagram.push_back(8'($urandom));
      repeat ($urandom_range(0, 4)) add_option(1'b0);
      pick = with_payload ? $urandom_range(0, 7) : 0;
      if (pick >= 3) datagram.push_back(MARKER_BYTE);
      if (pick >= 4) repeat ($urandom_range(1, 16)) datagram.push_back(8'($urandom));
   endfunction

   initial begin : result_sink
      int         stall;
      result_type got;
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got               = '0;
         got.kind          = kind_type'(rsp_tuser[2:0]);
         got.field_last    = rsp_tuser[3];
         got.message_end   = rsp_tlast;
         got.msg_type      = rsp_tdata[1:0];
         got.token_length  = rsp_tdata[5:2];
         got.code          = rsp_tdata[13:6];
         got.message_id    = rsp_tdata[29:14];
         got.option_number = rsp_tdata[45:30];
         got.option_length = rsp_tdata[61:46];
         got.data_value    = rsp_tdata[69:62];
         got.error_code    = error_type'(rsp_tdata[73:70]);
         board.check_result(got);
      end
   end

   initial begin : stimulus
      int pick;
      int keep;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // bare header, extreme field values
      datagram = '{8'h70, 8'hFF, 8'hFF, 8'hFF};
      send_datagram();
      // one-byte datagram: short header
      datagram = '{8'h55};
      send_datagram();
      // bad version
      datagram = '{8'h80, 8'h01, 8'h00, 8'h00};
      send_datagram();
      // token length above eight
      datagram = '{8'h49, 8'h00, 8'h00, 8'h00};
      send_datagram();
      // token cut short
      datagram = '{8'h42, 8'h01, 8'h00, 8'h01, 8'hAA};
      send_datagram();
      // marker as final byte
      datagram = '{8'h40, 8'h01, 8'h00, 8'h02, 8'hFF};
      send_datagram();
      // reserved delta, tail dropped
      datagram = '{8'h40, 8'h01, 8'h00, 8'h03, 8'hF0, 8'h00};
      send_datagram();

      while (live_bytes < TARGET_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            build_message(1'b1);
         end else if (pick < 77) begin
            build_message(1'b1);
            if (datagram.size() > 1) begin
               keep = $urandom_range(1, datagram.size() - 1);
               while (datagram.size() > keep) void'(datagram.pop_back());
            end
         end else if (pick < 87) begin
            build_message(1'b1);
            datagram[$urandom_range(0, datagram.size() - 1)] = 8'($urandom);
         end else if (pick < 95) begin
            build_message(1'b0);
            add_option(1'b1);
         end else begin
            datagram.delete();
            repeat ($urandom_range(1, 12)) datagram.push_back(8'($urandom));
         end
         send_datagram();
      end
      req_tvalid <= 1'b0;

      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("coap_message_parser_core_tb OK");
      end else begin
         $display("coap_message_parser_core_tb NOT OK");
      end
      $finish;
   end

endmodule
